[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker modules.
// The enclosing module must provide signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, skipped while reset is high.
`define PP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("polygon perimeter check failed");

// Check on every rising clock edge, reset cycles included.
`define PP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("polygon perimeter check failed");

`endif

[hw/rtl/pp_pkg.sv]
`default_nettype none
package pp_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int SUM_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH        = 4;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQR  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_ACC  = 5'b10000
   } back_state_type;

   // Round a bit count up to whole bytes.
   function automatic int byte_pad(input int bits);
      byte_pad = ((bits + 7) / 8) * 8;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/pp_queue.sv]
`default_nettype none
module pp_queue #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pp_front.sv]
`default_nettype none
module pp_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COORD_BITS-1:0] vertex_x,
   input  wire logic [COORD_BITS-1:0] vertex_y,
   input  wire logic                  last_vertex,
   // segment job: {emit, dy, dx}
   output logic                       job_valid,
   input  wire logic                  job_ready,
   output logic [2*COORD_BITS+2:0]    job_data
);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int JOB_W  = 2 * DIFF_W + 1;

   logic [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                  started_ff, started_in;
   logic                  pend_ff, pend_in;
   logic [JOB_W-1:0]      pend_job_ff, pend_job_in;
   logic                  accept;
   logic [DIFF_W-1:0]     seg_dx, seg_dy, close_dx, close_dy;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
      logic signed [DIFF_W-1:0] d;
      d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // hold new vertices while a closing segment is pending or the queue is full
   assign in_ready = !pend_ff && job_ready;
   assign accept   = in_valid && in_ready;

   assign seg_dx   = abs_diff(vertex_x, prev_x_ff);
   assign seg_dy   = abs_diff(vertex_y, prev_y_ff);
   assign close_dx = abs_diff(first_x_ff, vertex_x);
   assign close_dy = abs_diff(first_y_ff, vertex_y);

   always_comb begin
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      started_in  = started_ff;
      pend_in     = pend_ff;
      pend_job_in = pend_job_ff;
      job_valid   = 1'b0;
      job_data    = pend_job_ff;
      if (pend_ff) begin
         job_valid = 1'b1;
         if (job_ready) begin
            pend_in = 1'b0;
         end
      end else if (accept) begin
         prev_x_in = vertex_x;
         prev_y_in = vertex_y;
         if (!started_ff) begin
            first_x_in = vertex_x;
            first_y_in = vertex_y;
            started_in = !last_vertex;
            // a lone vertex closes on itself: zero-length closing segment
            job_valid  = last_vertex;
            job_data   = {1'b1, {DIFF_W{1'b0}}, {DIFF_W{1'b0}}};
         end else begin
            job_valid = 1'b1;
            job_data  = {1'b0, seg_dy, seg_dx};
            if (last_vertex) begin
               started_in  = 1'b0;
               pend_in     = 1'b1;
               pend_job_in = {1'b1, close_dy, close_dx};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         started_ff <= started_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      pend_job_ff <= pend_job_in;
   end

endmodule
`default_nettype wire

[hw/rtl/pp_back.sv]
`default_nettype none
module pp_back #(
   parameter int COORD_BITS = 16,
   parameter int SUM_BITS   = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    job_valid,
   output logic                         job_ready,
   input  wire logic [2*COORD_BITS+2:0] job_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [SUM_BITS-1:0]          out_perimeter,
   output logic                         out_overflowed
);
   import pp_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int ROOT_W = COORD_BITS + 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int CNT_W  = $clog2(ROOT_W);
   localparam int ACC_W  = ((SUM_BITS > ROOT_W) ? SUM_BITS : ROOT_W) + 1;

   back_state_type      state_ff, state_in;
   logic [DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic                emit_ff, emit_in;
   logic [SQ_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in, sum_next;
   logic                sat_ff, sat_in, sat_next;
   logic [ACC_W-1:0]    acc;
   logic                out_valid_ff, out_valid_in;
   logic [SUM_BITS-1:0] perim_ff, perim_in;
   logic                ovf_ff, ovf_in;
   logic                out_free;

   assign job_ready      = (state_ff == ST_IDLE);
   assign out_valid      = out_valid_ff;
   assign out_perimeter  = perim_ff;
   assign out_overflowed = ovf_ff;
   assign out_free       = !out_valid_ff || out_ready;

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   // saturating accumulate of the finished segment length
   assign acc = ACC_W'(sum_ff) + ACC_W'(root_ff);
   always_comb begin
      if (|acc[ACC_W-1:SUM_BITS]) begin
         sum_next = '1;
         sat_next = 1'b1;
      end else begin
         sum_next = acc[SUM_BITS-1:0];
         sat_next = sat_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      emit_in      = emit_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && !out_ready;
      perim_in     = perim_ff;
      ovf_in       = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               dx_in    = job_data[DIFF_W-1:0];
               dy_in    = job_data[2*DIFF_W-1:DIFF_W];
               emit_in  = job_data[2*DIFF_W];
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit per cycle, restoring shift-subtract
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!emit_ff) begin
               sum_in   = sum_next;
               sat_in   = sat_next;
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               perim_in     = sum_next;
               ovf_in       = sat_next;
               sum_in       = '0;
               sat_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      emit_ff  <= emit_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      perim_ff <= perim_in;
      ovf_ff   <= ovf_in;
   end

endmodule
`default_nettype wire

[hw/rtl/polygon_perimeter.sv]
// Perimeter of a closed polygon. Vertices stream in one transfer each as signed
// fixed-point x/y with 8 fraction bits; tlast marks the final vertex. Every edge
// length is the truncated square root of dx*dx + dy*dy, summed with saturation at
// all ones (tuser of the result then reads 1). The final vertex also adds the
// closing edge back to the first vertex and yields one result transfer, unsigned
// with 8 fraction bits; a single-vertex polygon yields zero. Each edge goes to the
// back-end square root unit, which works one root bit per cycle; the last vertex
// carries its own edge and the closing edge. A four-entry queue lets the input
// side run ahead of the root unit; a result waiting for rsp_tready holds the root
// unit only once the next result is due.
`default_nettype none
module polygon_perimeter #(
   parameter int COORD_BITS = pp_pkg::COORD_BITS_DEFAULT,
   parameter int SUM_BITS   = pp_pkg::SUM_BITS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // vertex_x, vertex_y
   input  wire logic [pp_pkg::byte_pad(2*COORD_BITS)-1:0] req_tdata,
   input  wire logic                                       req_tlast,
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   // perimeter
   output logic [pp_pkg::byte_pad(SUM_BITS)-1:0]          rsp_tdata,
   // overflowed
   output logic                                            rsp_tuser
);
   import pp_pkg::*;

   localparam int JOB_W = 2 * (COORD_BITS + 1) + 1;
   localparam int RSP_W = byte_pad(SUM_BITS);

   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic [JOB_W-1:0]    push_data, pop_data;
   logic [SUM_BITS-1:0] perimeter;

   pp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .vertex_x    (req_tdata[COORD_BITS-1:0]),
      .vertex_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .last_vertex (req_tlast),
      .job_valid   (push_valid),
      .job_ready   (push_ready),
      .job_data    (push_data)
   );

   pp_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pp_back #(
      .COORD_BITS (COORD_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job_ready      (pop_ready),
      .job_data       (pop_data),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_perimeter  (perimeter),
      .out_overflowed (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(perimeter);

endmodule
`default_nettype wire

[hw/rtl/pp_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module pp_checker #(
   parameter int COORD_BITS = 16,
   parameter int SUM_BITS   = 32
) (
   input wire logic                                       clock,
   input wire logic                                       reset,
   input wire logic                                       req_tvalid,
   input wire logic                                       req_tready,
   input wire logic                                       req_tlast,
   input wire logic                                       rsp_tvalid,
   input wire logic                                       rsp_tready,
   input wire logic [pp_pkg::byte_pad(SUM_BITS)-1:0]     rsp_tdata,
   input wire logic                                       rsp_tuser
);
   logic       last_transfer;
   logic       rsp_transfer;
   logic [7:0] open_ff, open_in;

   assign last_transfer = req_tvalid && req_tready && req_tlast;
   assign rsp_transfer  = rsp_tvalid && rsp_tready;

   // count closed polygons whose result has not been taken yet
   always_comb begin
      case ({last_transfer, rsp_transfer})
         2'b10:   open_in = open_ff + 1'b1;
         2'b01:   open_in = open_ff - 1'b1;
         default: open_in = open_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // a stalled result holds its payload
   `PP_ASSERT(rsp_hold_a, rsp_tvalid && !rsp_tready |=>
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // a saturated sum reads all ones
   `PP_ASSERT(sat_all_ones_a, rsp_tvalid && rsp_tuser |-> &rsp_tdata[SUM_BITS-1:0])
   // nothing left over once reset is released
   `PP_ASSERT_ALWAYS(rsp_idle_after_reset_a, reset |=> !rsp_tvalid)
   // a result only answers a polygon that has been closed
   `PP_ASSERT(rsp_owed_a, rsp_tvalid |-> open_ff != '0)

endmodule

bind polygon_perimeter pp_checker #(
   .COORD_BITS (COORD_BITS),
   .SUM_BITS   (SUM_BITS)
) u_pp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
